### rtl/est_pkg.sv
// Shared types and codes for the entity signature table.
package est_pkg;

  localparam int FUNC_W     = 3;
  localparam int ID_W       = 6;
  localparam int SIG_W      = 32;
  localparam int CNT_W      = 7;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - 1 - CNT_W;

  // function codes
  localparam logic [FUNC_W-1:0] FN_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_KILL   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_HAS    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_LIVE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ONE_HOT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL        = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;   // input word accepted this cycle
    logic exec;      // finish a single-result function
    logic scan_adv;  // evaluate current scan slot and move on
    logic flush;     // emit final query result
  } est_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_query;
    logic count_zero;
    logic scan_stall;
    logic scan_more;
    logic out_free;
  } est_stat_t;

endpackage

### rtl/est_ctrl.sv
// Controller state machine for the entity signature table.
module est_ctrl
  import est_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  est_stat_t stat,
  output est_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.capture = 1'b1;
          if (!stat.in_is_query) state_nxt = S_EXEC;
          else if (stat.count_zero) state_nxt = S_FLUSH;
          else state_nxt = S_SCAN;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stat.scan_stall) begin
          cmd.scan_adv = 1'b1;
          if (!stat.scan_more) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

### rtl/est_dpath.sv
// Datapath: mask memory, entity count, scan index and output register.
module est_dpath
  import est_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int MASK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  input  est_cmd_t              cmd,
  output est_stat_t             stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [MASK_BITS-1:0] mem [CAPACITY];
  logic [MASK_BITS-1:0] rd_data_r;

  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   id_r;
  logic [SIG_W-1:0]  sig_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  scan_i_r;
  logic              pend_valid_r;
  logic [IDX_W-1:0]  pend_id_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_found_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_last_r;

  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0]   in_id;
  logic [IDX_W-1:0]  cap_addr;
  logic [CNT_W-1:0]  count_dec;
  logic              out_free;
  logic              match;
  logic              emit_pend;
  logic              scan_more;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic              live;
  logic              one_hot;
  logic [SIG_W-1:0]  stored_ext;
  logic [STAT_W-1:0] ex_status;
  logic [ID_W-1:0]   ex_id;
  logic              ex_found;
  logic              ex_we;
  logic [IDX_W-1:0]  ex_waddr;
  logic [MASK_BITS-1:0] ex_wdata;

  assign in_func   = in_tuser;
  assign in_id     = in_tdata[ID_W-1:0];
  assign count_dec = count_r - CNT_W'(1);

  always_comb begin
    if (in_func == FN_KILL) cap_addr = count_dec[IDX_W-1:0];
    else if (in_func == FN_QUERY) cap_addr = '0;
    else cap_addr = in_id[IDX_W-1:0];
  end

  // bits of a request above the stored mask width never match
  assign stored_ext = SIG_W'(rd_data_r);
  assign match      = ((stored_ext & sig_r) == sig_r);
  assign out_free   = !out_valid_r || out_tready;
  assign emit_pend  = match && pend_valid_r;
  assign scan_more  = (CNT_W'(scan_i_r) + CNT_W'(1)) < count_r;

  assign rd_en   = cmd.capture || (cmd.scan_adv && scan_more);
  assign rd_addr = cmd.capture ? cap_addr : (scan_i_r + IDX_W'(1));

  assign stat.in_is_query = (in_func == FN_QUERY);
  assign stat.count_zero  = (count_r == '0);
  assign stat.scan_stall  = emit_pend && !out_free;
  assign stat.scan_more   = scan_more;
  assign stat.out_free    = out_free;

  assign live    = CNT_W'(id_r) < count_r;
  assign one_hot = $onehot(sig_r) && ((sig_r >> MASK_BITS) == '0);

  always_comb begin
    ex_status = ST_OK;
    ex_id     = '0;
    ex_found  = 1'b0;
    ex_we     = 1'b0;
    ex_waddr  = id_r[IDX_W-1:0];
    ex_wdata  = rd_data_r;
    count_nxt = count_r;
    case (func_r) inside
      FN_CREATE: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          ex_status = ST_FULL;
        end else begin
          ex_we     = 1'b1;
          ex_waddr  = count_r[IDX_W-1:0];
          ex_wdata  = '0;
          ex_id     = ID_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_KILL: begin
        if (!live) begin
          ex_status = ST_NOT_LIVE;
        end else begin
          // last entry was read at capture; move it into the freed slot
          ex_we     = 1'b1;
          count_nxt = count_dec;
        end
      end
      FN_ADD, FN_REMOVE: begin
        if (!live) begin
          ex_status = ST_NOT_LIVE;
        end else if (!one_hot) begin
          ex_status = ST_NOT_ONE_HOT;
        end else begin
          ex_we = 1'b1;
          if (func_r == FN_ADD) ex_wdata = rd_data_r | sig_r[MASK_BITS-1:0];
          else ex_wdata = rd_data_r & ~sig_r[MASK_BITS-1:0];
        end
      end
      FN_HAS: begin
        if (!live) ex_status = ST_NOT_LIVE;
        else ex_found = match;
      end
      default: ex_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ex_we) mem[ex_waddr] <= ex_wdata;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      id_r   <= in_id;
      sig_r  <= in_tdata[ID_W +: SIG_W];
    end
    if (cmd.capture) pend_id_r <= '0;
    else if (cmd.scan_adv && match) pend_id_r <= scan_i_r;
    if (cmd.capture) scan_i_r <= '0;
    else if (cmd.scan_adv && scan_more) scan_i_r <= scan_i_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) count_r <= count_nxt;
      if (cmd.capture) pend_valid_r <= 1'b0;
      else if (cmd.scan_adv && match) pend_valid_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec || cmd.flush || (cmd.scan_adv && emit_pend)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= ex_status;
      out_id_r     <= ex_id;
      out_found_r  <= ex_found;
      out_count_r  <= count_nxt;
      out_last_r   <= 1'b1;
    end else if (cmd.scan_adv && emit_pend) begin
      // a newer match exists, so the held one is not the last
      out_status_r <= ST_OK;
      out_id_r     <= ID_W'(pend_id_r);
      out_found_r  <= 1'b1;
      out_count_r  <= count_r;
      out_last_r   <= 1'b0;
    end else if (cmd.flush) begin
      out_status_r <= ST_OK;
      out_id_r     <= pend_valid_r ? ID_W'(pend_id_r) : '0;
      out_found_r  <= pend_valid_r;
      out_count_r  <= count_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_count_r, out_found_r, out_id_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/entity_signature_table.sv
// Create, kill, add, remove, has: the mask read is registered at accept and the result is
// registered in the execute state once the output is free; no new word is accepted before then.
// Query: one live slot per cycle through the single read port, unless a held match waits on the output.
// A result waiting at the output does not block accepting the next input word.
// Reset (rst_n low, synchronous) clears the entity count, controller state and valid flags only;
// the mask memory needs no clearing pass, since slots are written before they go live.
module entity_signature_table
  import est_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int MASK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entity_id, signature, zero pad
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_id, found, live_count, zero pad
  output logic [STAT_W-1:0]     out_tuser,  // status
  output logic                  out_tlast
);

  est_cmd_t  cmd;
  est_stat_t stat;

  est_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  est_dpath #(
    .CAPACITY  (CAPACITY),
    .MASK_BITS (MASK_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/est_checker.sv
// Port-level assertions for the entity signature table, bound to the top level.
module est_checker
  import est_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic                  out_tlast
);

  localparam int FOUND_POS = ID_W;
  localparam int CNT_LSB   = ID_W + 1;

  logic [CNT_W-1:0] live_count;
  assign live_count = out_tdata[CNT_LSB +: CNT_W];

  // one word at a time: no accept in the cycle right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> live_count <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> live_count == CNT_W'(CAPACITY))
    else $error("full status with table not full");

  // only query matches come out without last
  a_not_last_is_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[FOUND_POS] && out_tuser == ST_OK)
    else $error("non-final word that is not a query match");

endmodule

bind entity_signature_table est_checker #(.CAPACITY(CAPACITY)) u_est_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);

### bench/tb.sv
// Self-checking bench for the entity signature table: directed, capacity, back-pressure, random.
module tb;
  import est_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 64;
  localparam int MASK_BITS  = 32;
  localparam int HALF_CLK   = 6;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 200;
  localparam int N_RANDOM   = 45;

  // codes the block ignores
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   result_id;
    logic              found;
    logic [CNT_W-1:0]  live_count;
    logic              last;
  } table_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // entity_id, signature, zero pad
  logic [FUNC_W-1:0]     in_tuser = '0;   // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // result_id, found, live_count, zero pad
  logic [STAT_W-1:0]     out_tuser;       // status
  logic                  out_tlast;

  // shadow copy of the table
  logic [MASK_BITS-1:0] slot_mask [CAPACITY];
  logic [CNT_W-1:0]     live_n = '0;
  table_result_t        due_results [$];

  int  n_err = 0;
  int  n_sent = 0;
  int  n_results = 0;
  int  n_queries = 0;
  int  n_full = 0;
  int  hold_left = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  entity_signature_table #(
    .CAPACITY  (CAPACITY),
    .MASK_BITS (MASK_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #HALF_CLK clk = 1'b1;
    #HALF_CLK clk = 1'b0;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_init
    initial slot_mask[g] = '0;
  end

  function automatic void push_due(logic [STAT_W-1:0] status, logic [ID_W-1:0] rid,
                                   logic found, logic last);
    table_result_t r;
    r.status     = status;
    r.result_id  = rid;
    r.found      = found;
    r.live_count = live_n;
    r.last       = last;
    due_results.push_back(r);
  endfunction

  // updates the shadow table for one accepted word and queues what the block should emit
  function automatic void apply_table_op(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                         logic [SIG_W-1:0] sig);
    logic             is_live;
    logic             one_hot;
    logic [ID_W-1:0]  new_id;
    int               hits;
    int               k;
    is_live = (CNT_W'(id) < live_n);
    one_hot = (sig != '0) && ((sig & (sig - 1'b1)) == '0);
    case (fn)
      FN_CREATE: begin
        if (live_n >= CAPACITY) begin
          n_full++;
          push_due(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          new_id = live_n[ID_W-1:0];
          slot_mask[new_id] = '0;
          live_n = live_n + 1'b1;
          push_due(ST_OK, new_id, 1'b0, 1'b1);
        end
      end
      FN_KILL: begin
        if (!is_live) begin
          push_due(ST_NOT_LIVE, '0, 1'b0, 1'b1);
        end else begin
          slot_mask[id] = slot_mask[live_n - 1'b1];
          live_n = live_n - 1'b1;
          push_due(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      FN_ADD, FN_REMOVE: begin
        if (!is_live) begin
          push_due(ST_NOT_LIVE, '0, 1'b0, 1'b1);
        end else if (!one_hot) begin
          push_due(ST_NOT_ONE_HOT, '0, 1'b0, 1'b1);
        end else begin
          if (fn == FN_ADD) slot_mask[id] = slot_mask[id] | sig;
          else slot_mask[id] = slot_mask[id] & ~sig;
          push_due(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      FN_HAS: begin
        if (!is_live) push_due(ST_NOT_LIVE, '0, 1'b0, 1'b1);
        else push_due(ST_OK, '0, (slot_mask[id] & sig) == sig, 1'b1);
      end
      FN_QUERY: begin
        n_queries++;
        hits = 0;
        for (k = 0; k < live_n; k++) begin
          if ((slot_mask[k] & sig) == sig) hits++;
        end
        if (hits == 0) begin
          push_due(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (k = 0; k < live_n; k++) begin
            if ((slot_mask[k] & sig) == sig) begin
              hits--;
              push_due(ST_OK, ID_W'(k), 1'b1, hits == 0);
            end
          end
        end
      end
      default: push_due(ST_OK, '0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int rx_stall();
    int r;
    if (rx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("tb: %s", msg);
  endtask

  // one word on the input side; returns right after the accepting edge
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                           input logic [SIG_W-1:0] sig);
    int gap;
    gap = tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - SIG_W - ID_W){1'b0}}, sig, id};
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
    apply_table_op(fn, id, sig);
    n_sent++;
  endtask

  // live id most of the time, now and then an id at or past the end
  function automatic logic [ID_W-1:0] pick_id();
    if (live_n < CAPACITY && $urandom_range(0, 7) == 0)
      return ID_W'($urandom_range(live_n, CAPACITY - 1));
    return ID_W'($urandom_range(0, live_n - 1));
  endfunction

  function automatic logic [SIG_W-1:0] pick_bit();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? '0 : $urandom;
    return 32'h1 << $urandom_range(0, MASK_BITS - 1);
  endfunction

  always begin : rx_side
    int g;
    @(negedge clk);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      while (hold_left > 0) begin
        @(negedge clk);
        hold_left--;
      end
    end else begin
      g = rx_stall();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = out_tuser;
      got.result_id  = out_tdata[ID_W-1:0];
      got.found      = out_tdata[ID_W];
      got.live_count = out_tdata[ID_W+1 +: CNT_W];
      got.last       = out_tlast;
      n_results++;
      if (due_results.size() == 0) begin
        note_error($sformatf("unexpected word st=%0d id=%0d found=%0d live=%0d last=%0d",
                             got.status, got.result_id, got.found, got.live_count, got.last));
      end else begin
        want = due_results.pop_front();
        if (got != want)
          note_error($sformatf({"mismatch exp st=%0d id=%0d found=%0d live=%0d last=%0d",
                                " got st=%0d id=%0d found=%0d live=%0d last=%0d"},
                               want.status, want.result_id, want.found, want.live_count,
                               want.last, got.status, got.result_id, got.found,
                               got.live_count, got.last));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("tb: done, errors");
    $finish;
  end

  task automatic test_directed();
    send_word(FN_QUERY, 6'd0, 32'h0000_0000);    // empty table
    send_word(FN_HAS, 6'd0, 32'h0000_0001);
    send_word(FN_KILL, 6'd63, 32'hFFFF_FFFF);
    send_word(FN_ADD, 6'd0, 32'h0000_0003);      // not live wins over bad mask
    send_word(FN_CREATE, 6'd63, 32'hFFFF_FFFF);
    send_word(FN_ADD, 6'd0, 32'h0000_0000);
    send_word(FN_ADD, 6'd0, 32'h0000_0003);
    send_word(FN_ADD, 6'd0, 32'h0000_0001);
    send_word(FN_ADD, 6'd0, 32'h8000_0000);
    send_word(FN_HAS, 6'd0, 32'h8000_0001);
    send_word(FN_HAS, 6'd0, 32'hFFFF_FFFF);
    send_word(FN_HAS, 6'd0, 32'h0000_0000);
    send_word(FN_REMOVE, 6'd0, 32'h8000_0000);
    send_word(FN_REMOVE, 6'd0, 32'hC000_0000);
    send_word(FN_CREATE, 6'd0, 32'h0000_0000);
    send_word(FN_CREATE, 6'd0, 32'h0000_0000);
    send_word(FN_ADD, 6'd2, 32'h0000_0001);
    send_word(FN_QUERY, 6'd0, 32'h0000_0001);
    send_word(FN_QUERY, 6'd63, 32'h0000_0000);
    send_word(FN_KILL, 6'd0, 32'h0000_0000);     // last slot moves into slot 0
    send_word(FN_QUERY, 6'd0, 32'h0000_0001);
    send_word(FN_SPARE_6, 6'd63, 32'hFFFF_FFFF);
    send_word(FN_SPARE_7, 6'd21, 32'h5555_5555);
    send_word(FN_REMOVE, 6'd2, 32'h0000_0001);
    send_word(FN_QUERY, 6'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_capacity();
    while (live_n < CAPACITY) begin
      send_word(FN_CREATE, ID_W'($urandom), $urandom);
      if ($urandom_range(0, 2) == 0)
        send_word(FN_ADD, ID_W'(live_n - 1'b1), 32'h1 << $urandom_range(0, MASK_BITS - 1));
    end
    send_word(FN_CREATE, ID_W'($urandom), $urandom);   // no room left
    send_word(FN_QUERY, ID_W'($urandom), 32'h0000_0000);
    send_word(FN_ADD, 6'd63, 32'h0000_0020);
    send_word(FN_HAS, 6'd63, 32'h0000_0020);
    send_word(FN_QUERY, 6'd0, 32'h0000_0020);
    while (live_n > 16) send_word(FN_KILL, pick_id(), $urandom);
  endtask

  // output held off while queries and has words keep coming, so the input side backs up
  task automatic test_pressure();
    int k;
    hold_left = HOLD_LEN;
    for (k = 0; k < 24; k++) begin
      if (k % 3 == 0) send_word(FN_QUERY, '0, '0);
      else send_word(FN_HAS, pick_id(), $urandom & $urandom);
    end
  endtask

  task automatic send_random_op();
    int                 cat;
    logic [FUNC_W-1:0]  fn;
    logic [ID_W-1:0]    id;
    logic [SIG_W-1:0]   sig;
    cat = $urandom_range(0, 9);
    if (live_n == 0 && cat != 0) cat = 1;
    id  = ID_W'($urandom);
    sig = $urandom;
    case (cat)
      0: begin
        fn = FUNC_W'($urandom);
        if ($urandom_range(0, 3) == 0) sig = 32'h1 << $urandom_range(0, MASK_BITS - 1);
      end
      1, 2: begin
        if (live_n < 40) fn = FN_CREATE;
        else begin
          fn = FN_KILL;
          id = pick_id();
        end
      end
      3: begin
        if (live_n > 6) begin
          fn = FN_KILL;
          id = pick_id();
        end else fn = FN_CREATE;
      end
      4, 5, 6: begin
        fn  = (cat == 6) ? FN_REMOVE : FN_ADD;
        id  = pick_id();
        sig = pick_bit();
      end
      7: begin
        fn = FN_HAS;
        id = pick_id();
        if ($urandom_range(0, 3) != 0) sig = slot_mask[id] & $urandom;
      end
      default: begin
        fn = FN_QUERY;
        case ($urandom_range(0, 9))
          0:       sig = $urandom;
          1, 2:    sig = 32'h1 << $urandom_range(0, MASK_BITS - 1);
          default: sig = slot_mask[$urandom_range(0, live_n - 1)] & $urandom & $urandom;
        endcase
      end
    endcase
    send_word(fn, id, sig);
  endtask

  task automatic test_random();
    int k;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 39) begin
        tx_steady = ~tx_steady;
        rx_steady = $urandom_range(0, 1);
      end
      send_random_op();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : main
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_pressure();
    test_random();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (due_results.size() != 0) note_error("expected words never arrived");
    $display("tb: %0d words sent, %0d results checked, %0d queries, %0d creates on a full table",
             n_sent, n_results, n_queries, n_full);
    $display("tb: covered every function, bad ids and masks, fill to capacity, output hold-off");
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", n_err);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/est_pkg.sv
rtl/est_ctrl.sv
rtl/est_dpath.sv
rtl/entity_signature_table.sv
rtl/est_checker.sv
bench/tb.sv
